@@ rtl/hil3_pkg.sv @@
// Package for the 3D Hilbert curve index pipeline.
// Holds the shared widths, codes and the stage control struct; no dependencies.
package hil3_pkg;

    localparam int unsigned CFG_W   = 6;
    localparam int unsigned COORD_W = 21;
    localparam int unsigned LVL_W   = 5;
    localparam int unsigned IDX_W   = 64;

    // reciprocal of three for narrow values: floor(v / 3) == (v * 43) >> 7 for v < 128
    localparam int unsigned DIV3_MUL   = 43;
    localparam int unsigned DIV3_SHIFT = 7;
    localparam int unsigned CFG_RESET  = 63;

    typedef struct packed {
        logic             outside;
        logic             zero;
        logic [LVL_W-1:0] lvl;
    } stage_ctl_t;

endpackage

@@ rtl/hil3_entry.sv @@
// Entry stage: aligns the coordinates so the top level sits in the top bit and applies
// the Moore transform of the top level. Depends on hil3_pkg.
module hil3_entry import hil3_pkg::*; #(
    parameter int unsigned MAX_LEVELS = 21
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [COORD_W-1:0]        in_x,
    input  logic [COORD_W-1:0]        in_y,
    input  logic [COORD_W-1:0]        in_z,
    input  stage_ctl_t                in_ctl,
    output logic                      out_valid,
    output logic [MAX_LEVELS-1:0]     out_x,
    output logic [MAX_LEVELS-1:0]     out_y,
    output logic [MAX_LEVELS-1:0]     out_z,
    output logic [3*MAX_LEVELS-1:0]   out_acc,
    output stage_ctl_t                out_ctl
);

    localparam int unsigned CW    = MAX_LEVELS;
    localparam int unsigned ACC_W = 3 * MAX_LEVELS;
    localparam logic [CW-1:0] BELOW = CW'((64'd1 << (CW - 1)) - 64'd1);

    logic             valid_reg;
    logic [CW-1:0]    x_reg, y_reg, z_reg;
    logic [ACC_W-1:0] acc_reg;
    stage_ctl_t       ctl_reg;

    logic [LVL_W-1:0] sh;
    logic [CW-1:0]    xa, ya, za;
    logic [CW-1:0]    x_next, y_next, z_next;
    logic [ACC_W-1:0] acc_next;
    logic             rx, ry, rz;

    always_comb begin
        sh = LVL_W'(MAX_LEVELS) - in_ctl.lvl;
        xa = in_x[CW-1:0] << sh;
        ya = in_y[CW-1:0] << sh;
        za = in_z[CW-1:0] << sh;
        rx = xa[CW-1];
        ry = ya[CW-1];
        rz = za[CW-1];
        acc_next = ACC_W'({rx, rx ^ ry, rx ^ ry ^ rz});
        if (!rx) begin
            ya = ya ^ BELOW;
            xa = xa ^ BELOW;
        end
        if (rz) begin
            ya = ya ^ BELOW;
        end else begin
            za = za ^ BELOW;
        end
        x_next = ya;
        y_next = za;
        z_next = xa;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            acc_reg <= acc_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_acc   = acc_reg;
    assign out_ctl   = ctl_reg;

endmodule

@@ rtl/hil3_level.sv @@
// One level of the curve: Gray decode of the three coordinate bits, then the
// Hilbert inversions and swaps below that level. Depends on hil3_pkg.
module hil3_level import hil3_pkg::*; #(
    parameter int unsigned MAX_LEVELS = 21,
    parameter int unsigned STEP       = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [MAX_LEVELS-1:0]     in_x,
    input  logic [MAX_LEVELS-1:0]     in_y,
    input  logic [MAX_LEVELS-1:0]     in_z,
    input  logic [3*MAX_LEVELS-1:0]   in_acc,
    input  stage_ctl_t                in_ctl,
    output logic                      out_valid,
    output logic [MAX_LEVELS-1:0]     out_x,
    output logic [MAX_LEVELS-1:0]     out_y,
    output logic [MAX_LEVELS-1:0]     out_z,
    output logic [3*MAX_LEVELS-1:0]   out_acc,
    output stage_ctl_t                out_ctl
);

    localparam int unsigned CW    = MAX_LEVELS;
    localparam int unsigned ACC_W = 3 * MAX_LEVELS;
    localparam int unsigned POS   = MAX_LEVELS - 1 - STEP;
    localparam logic [CW-1:0] M   = CW'((64'd1 << POS) - 64'd1);

    logic             valid_reg;
    logic [CW-1:0]    x_reg, y_reg, z_reg;
    logic [ACC_W-1:0] acc_reg;
    stage_ctl_t       ctl_reg;

    logic [CW-1:0]    x, y, z, t;
    logic [ACC_W-1:0] acc_next;
    logic             rx, ry, rz, active;

    always_comb begin
        x = in_x;
        y = in_y;
        z = in_z;
        rx = x[POS];
        ry = y[POS];
        rz = z[POS];
        active = LVL_W'(STEP) < in_ctl.lvl;
        acc_next = active ? {in_acc[ACC_W-4:0], rx, rx ^ ry, rx ^ ry ^ rz} : in_acc;
        if (rx) begin
            if (rz) begin
                y = y ^ M;
            end else begin
                z = z ^ M;
                if (ry) begin
                    t = x; x = y; y = t;
                end else begin
                    t = y; y = z; z = t;
                end
            end
            x = x ^ M;
        end else if (!rz) begin
            if (ry) begin
                z = z ^ M;
                t = x; x = y; y = t;
                x = x ^ M;
            end else begin
                t = y; y = z; z = t;
            end
        end
        t = y; y = z; z = t;
        t = x; x = z; z = t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x;
            y_reg   <= y;
            z_reg   <= z;
            acc_reg <= acc_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_acc   = acc_reg;
    assign out_ctl   = ctl_reg;

endmodule

@@ rtl/hil3_out.sv @@
// Output stage: selects the final index and holds it in an output register with a
// skid register behind it, so the pipeline enable comes from a flop. Depends on hil3_pkg.
module hil3_out import hil3_pkg::*; #(
    parameter int unsigned MAX_LEVELS = 21
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    output logic                      en,
    input  logic                      in_valid,
    input  logic [3*MAX_LEVELS-1:0]   in_acc,
    input  stage_ctl_t                in_ctl,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [IDX_W-1:0]          m_tdata
);

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [IDX_W-1:0] skid_data_reg;

    logic [IDX_W-1:0] result;
    logic             take, push;

    always_comb begin
        if (in_ctl.zero) begin
            result = '0;
        end else if (in_ctl.outside) begin
            result = '1;
        end else begin
            result = IDX_W'(in_acc);
        end
        en   = !skid_valid_reg;
        take = out_valid_reg && m_tready;
        push = en && in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !take) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/hilbert_3d_index.sv @@
// Top level of the 3D Hilbert curve index pipeline: configuration register, entry stage,
// one stage per lower level, output stage. Depends on hil3_pkg and the hil3_* modules.
//
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   tdata: grid_x, grid_y, grid_z; tuser: outside_box
//  m_        out        m_tvalid / m_tready   tdata: curve_index
//  cfg_      in         cfg_valid / cfg_ready cfg_data: index_bits
//
// An accepted transaction reaches m_tvalid through one entry stage, MAX_LEVELS - 1 level
// stages and the output register. One transaction enters per cycle while s_tready is high.
// Reset clears all valid bits and sets index_bits to 63. A stall on m_ fills the skid
// register and holds every stage until it drains; cfg_ready is always high.
module hilbert_3d_index import hil3_pkg::*; #(
    parameter int unsigned MAX_LEVELS = 21
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // grid_x [20:0], grid_y [41:21], grid_z [62:42], zero
    input  logic [0:0]        s_tuser,   // outside_box
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [IDX_W-1:0]  m_tdata,   // curve_index
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data   // index_bits
);

    localparam int unsigned CW    = MAX_LEVELS;
    localparam int unsigned ACC_W = 3 * MAX_LEVELS;
    localparam int unsigned PROD_W = CFG_W + 7;

    logic             zero_reg;
    logic [LVL_W-1:0] lvl_reg;

    logic [CFG_W:0]   cfg_plus;
    logic [PROD_W-1:0] cfg_prod;
    logic [LVL_W-1:0] cfg_lvl;
    logic [LVL_W-1:0] lvl_next;
    logic             en;
    stage_ctl_t       in_ctl;

    logic             vld_s [MAX_LEVELS];
    logic [CW-1:0]    x_s   [MAX_LEVELS];
    logic [CW-1:0]    y_s   [MAX_LEVELS];
    logic [CW-1:0]    z_s   [MAX_LEVELS];
    logic [ACC_W-1:0] acc_s [MAX_LEVELS];
    stage_ctl_t       ctl_s [MAX_LEVELS];

    always_comb begin
        cfg_plus = {1'b0, cfg_data} + (CFG_W + 1)'(2);
        cfg_prod = PROD_W'(cfg_plus) * PROD_W'(DIV3_MUL);
        cfg_lvl  = cfg_prod[DIV3_SHIFT +: LVL_W];
        lvl_next = (cfg_lvl > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : cfg_lvl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reg <= (CFG_RESET == 0);
            lvl_reg  <= LVL_W'(MAX_LEVELS);
        end else if (cfg_valid) begin
            zero_reg <= (cfg_data == '0);
            lvl_reg  <= lvl_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = en;

    always_comb begin
        in_ctl.outside = s_tuser[0];
        in_ctl.zero    = zero_reg;
        in_ctl.lvl     = lvl_reg;
    end

    hil3_entry #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_x      (s_tdata[20:0]),
        .in_y      (s_tdata[41:21]),
        .in_z      (s_tdata[62:42]),
        .in_ctl    (in_ctl),
        .out_valid (vld_s[0]),
        .out_x     (x_s[0]),
        .out_y     (y_s[0]),
        .out_z     (z_s[0]),
        .out_acc   (acc_s[0]),
        .out_ctl   (ctl_s[0])
    );

    for (genvar k = 1; k < MAX_LEVELS; k++) begin : g_level
        hil3_level #(
            .MAX_LEVELS (MAX_LEVELS),
            .STEP       (k)
        ) u_level (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld_s[k-1]),
            .in_x      (x_s[k-1]),
            .in_y      (y_s[k-1]),
            .in_z      (z_s[k-1]),
            .in_acc    (acc_s[k-1]),
            .in_ctl    (ctl_s[k-1]),
            .out_valid (vld_s[k]),
            .out_x     (x_s[k]),
            .out_y     (y_s[k]),
            .out_z     (z_s[k]),
            .out_acc   (acc_s[k]),
            .out_ctl   (ctl_s[k])
        );
    end

    hil3_out #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_s[MAX_LEVELS-1]),
        .in_acc   (acc_s[MAX_LEVELS-1]),
        .in_ctl   (ctl_s[MAX_LEVELS-1]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sim/hilbert_3d_index_tb.sv @@
// Testbench for hilbert_3d_index: directed and random vertices, with a local curve-index
// predictor and an in-order scoreboard. Depends on hil3_pkg and the hilbert_3d_index RTL.
`timescale 1ns / 1ps

module hilbert_3d_index_tb;
    import hil3_pkg::*;

    localparam int          MAX_LEVELS   = 21;
    localparam int          DRAIN_CYCLES = MAX_LEVELS + 6;
    localparam int          LIMIT_CYCLES = 300000;
    localparam int          BLOCK_ITEMS  = 70;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;   // grid_x [20:0], grid_y [41:21], grid_z [62:42], zero
    logic [0:0]          s_tuser   = '0;   // outside_box
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [IDX_W-1:0]    m_tdata;          // curve_index
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;   // index_bits

    logic [CFG_W-1:0]    index_bits_model = CFG_W'(CFG_RESET);
    logic [IDX_W-1:0]    pending_index_q[$];
    int                  send_idle = 0;
    int                  recv_idle = 0;
    int                  sent_vertices = 0;
    int                  checked_indices = 0;
    int                  bits_writes = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    hilbert_3d_index #(.MAX_LEVELS(MAX_LEVELS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [IDX_W-1:0] hilbert_index(
        input logic [COORD_W-1:0] gx,
        input logic [COORD_W-1:0] gy,
        input logic [COORD_W-1:0] gz,
        input logic               outside,
        input logic [CFG_W-1:0]   bits
    );
        int unsigned      levels;
        int unsigned      top;
        int unsigned      lv;
        logic [31:0]      mask;
        logic [31:0]      below;
        logic [31:0]      m;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [31:0]      t;
        logic             rx;
        logic             ry;
        logic             rz;
        logic [IDX_W-1:0] acc;
        if (bits == '0) begin
            return '0;
        end
        if (outside) begin
            return '1;
        end
        levels = (int'(bits) + 2) / 3;
        if (levels > MAX_LEVELS) begin
            levels = MAX_LEVELS;
        end
        mask  = (32'd1 << levels) - 32'd1;
        x     = {11'd0, gx} & mask;
        y     = {11'd0, gy} & mask;
        z     = {11'd0, gz} & mask;
        top   = levels - 1;
        below = (32'd1 << top) - 32'd1;
        rx    = x[top];
        ry    = y[top];
        rz    = z[top];
        acc   = IDX_W'({rx, rx ^ ry, rx ^ ry ^ rz});
        // top level: Moore transform
        if (!rx) begin
            y = y ^ below;
            x = x ^ below;
        end
        if (rz) begin
            y = y ^ below;
        end else begin
            z = z ^ below;
        end
        t = x; x = z; z = t;
        t = x; x = y; y = t;
        for (int j = int'(top); j > 0; j--) begin
            lv  = j - 1;
            m   = (32'd1 << lv) - 32'd1;
            rx  = x[lv];
            ry  = y[lv];
            rz  = z[lv];
            acc = {acc[IDX_W-4:0], rx, rx ^ ry, rx ^ ry ^ rz};
            if (rx) begin
                if (rz) begin
                    y = y ^ m;
                end else begin
                    z = z ^ m;
                    if (ry) begin
                        t = x; x = y; y = t;
                    end else begin
                        t = y; y = z; z = t;
                    end
                end
                x = x ^ m;
            end else if (!rz) begin
                if (ry) begin
                    z = z ^ m;
                    t = x; x = y; y = t;
                    x = x ^ m;
                end else begin
                    t = y; y = z; z = t;
                end
            end
            t = y; y = z; z = t;
            t = x; x = z; z = t;
        end
        return acc;
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        logic [IDX_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_index_q.size() == 0) begin
                $error("curve_index: unexpected transaction, expected none, actual %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_index_q.pop_front();
                if (m_tdata !== want) begin
                    $error("curve_index: expected %h, actual %h", want, m_tdata);
                    mismatches++;
                end
                checked_indices++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("hilbert_3d_index_tb: done, errors");
            $finish;
        end
    end

    task automatic send_vertex(
        input logic [COORD_W-1:0] gx,
        input logic [COORD_W-1:0] gy,
        input logic [COORD_W-1:0] gz,
        input logic               outside
    );
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, gz, gy, gx};
        s_tuser  <= outside;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_index_q.push_back(hilbert_index(gx, gy, gz, outside, index_bits_model));
        sent_vertices++;
        @(negedge aclk);
    endtask

    // hold the sender until every expected index is back, then let the pipeline settle
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_index_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_index_bits(input logic [CFG_W-1:0] bits);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        index_bits_model = bits;
        bits_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_vertex();
        int                 kind;
        logic [COORD_W-1:0] c[3];
        kind = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            c[i] = COORD_W'($urandom);
            if (kind >= 8 && kind < 18) begin
                case ($urandom_range(2))
                    0:       c[i] = '0;
                    1:       c[i] = COORD_MAX;
                    default: c[i] = COORD_W'($urandom);
                endcase
            end
        end
        send_vertex(c[0], c[1], c[2], kind < 8);
    endtask

    task automatic test_reset_extremes();
        send_vertex('0, '0, '0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_vertex('0, '0, '0, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(21'h100000, '0, '0, 1'b0);
        send_vertex('0, 21'h100000, '0, 1'b0);
        send_vertex('0, '0, 21'h100000, 1'b0);
        send_vertex(21'd1, 21'd0, 21'd0, 1'b0);
        send_vertex(21'h155555, 21'h0AAAAA, 21'h155555, 1'b0);
        send_vertex(21'h0AAAAA, 21'h155555, 21'h0AAAAA, 1'b0);
    endtask

    task automatic test_bit_requests();
        logic [CFG_W-1:0] req[6] = '{6'd0, 6'd1, 6'd3, 6'd4, 6'd62, 6'd63};
        foreach (req[i]) begin
            apply_index_bits(req[i]);
            send_vertex(COORD_MAX, COORD_MAX, 21'h0F0F0F, 1'b0);
            send_vertex(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'b1);
        end
    endtask

    task automatic test_random_stream(input int send_pct, input int recv_pct, input int blocks);
        send_idle = send_pct;
        recv_idle = recv_pct;
        for (int b = 0; b < blocks; b++) begin
            case ($urandom_range(4))
                0:       apply_index_bits(6'd63);
                1:       apply_index_bits(6'd0);
                2:       apply_index_bits(CFG_W'($urandom_range(1, 6)));
                default: apply_index_bits(CFG_W'($urandom_range(63)));
            endcase
            repeat (BLOCK_ITEMS) send_random_vertex();
        end
        drain_pipeline();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle = 0;
        recv_idle = 30;
        test_reset_extremes();
        test_bit_requests();
        test_random_stream(9, 84, 8);
        test_random_stream(84, 9, 8);
        test_random_stream(0, 0, 8);
        apply_index_bits(6'd63);
        if (pending_index_q.size() != 0) begin
            $error("curve_index: expected %0d more transactions, actual none",
                   pending_index_q.size());
            mismatches++;
        end
        $display("hilbert_3d_index_tb: %0d vertices sent, %0d indices checked",
                 sent_vertices, checked_indices);
        $display("hilbert_3d_index_tb: %0d index_bits writes, three idle profiles, %0d mismatches",
                 bits_writes, mismatches);
        if (mismatches == 0) begin
            $display("hilbert_3d_index_tb: done, clean");
        end else begin
            $display("hilbert_3d_index_tb: done, errors");
        end
        $finish;
    end

endmodule
